[design/gcpl_pkg.sv]
package gcpl_pkg;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_X_GAIN_U      = 3'd0,
        REG_X_GAIN_V      = 3'd1,
        REG_Y_GAIN_U      = 3'd2,
        REG_Y_GAIN_V      = 3'd3,
        REG_ORIGIN_XY     = 3'd4,
        REG_PERSPECTIVE   = 3'd5,
        REG_IMAGE_WIDTH   = 3'd6,
        REG_IMAGE_HEIGHT  = 3'd7
    } t_reg_index;

    localparam int CFG_W         = 64;
    localparam int GRID_MAX_SIZE = 177;
    localparam int IMAGE_MAX_DIM = 4096;
    localparam int DIM_W         = 13;

    // datapath widths
    localparam int COEF_W   = 32;
    localparam int UV_W     = 10;                // 2*index+1 with a sign bit
    localparam int PROD_W   = COEF_W + UV_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int FRAC_SH  = 15;
    localparam int NUM_W    = SUM_W + FRAC_SH + 1;
    localparam int DEN_W    = SUM_W + 1;
    localparam int QBITS    = 15;
    localparam int DIV_LAT  = QBITS + 2;
    localparam int COORD_W  = 16;
    localparam int ADDR_W   = 24;

    typedef struct packed {
        logic [7:0] cell_col;
        logic [7:0] cell_row;
    } t_cell_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
        logic                      in_image;
        logic [ADDR_W-1:0]         pixel_address;
    } t_pix_out;

    // side information that rides alongside the divider
    typedef struct packed {
        logic grid_ok;
        logic den_zero;
    } t_meta;

endpackage

[design/gcpl_div.sv]
module gcpl_div (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [gcpl_pkg::NUM_W-1:0]           i_num,
    input  logic [gcpl_pkg::DEN_W-1:0]           i_den,
    input  logic                                 i_neg,
    output logic signed [gcpl_pkg::COORD_W-1:0]  o_quo
);

    localparam int NW = gcpl_pkg::NUM_W;
    localparam int DW = gcpl_pkg::DEN_W;
    localparam int QB = gcpl_pkg::QBITS;
    localparam int CW = gcpl_pkg::COORD_W;

    logic [NW-1:0] r_rem [0:QB];
    logic [DW-1:0] r_den [0:QB];
    logic [QB-1:0] r_q   [0:QB];
    logic          r_neg [0:QB];
    logic          r_ovf [0:QB];
    logic signed [CW-1:0] r_quo;
    logic signed [CW-1:0] n_quo;
    logic          n_ovf;

    // entry stage: magnitude too large for the result range saturates
    assign n_ovf = (i_num >= (NW'(i_den) << QB));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= i_neg;
            r_ovf[0] <= n_ovf;
        end
    end

    // one restoring step per stage, most significant quotient bit first
    for (genvar s = 1; s <= QB; s++) begin : g_step
        localparam int K = QB - s;
        logic [NW-1:0] trial;
        logic          take;
        assign trial = NW'(r_den[s-1]) << K;
        assign take  = (r_rem[s-1] >= trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= take ? (r_rem[s-1] - trial) : r_rem[s-1];
                r_den[s] <= r_den[s-1];
                r_q[s]   <= r_q[s-1] | (take ? (QB'(1) << K) : QB'(0));
                r_neg[s] <= r_neg[s-1];
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    // sign and saturation
    always_comb begin
        if (r_ovf[QB]) begin
            n_quo = r_neg[QB] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else if (r_neg[QB]) begin
            n_quo = -$signed({1'b0, r_q[QB]});
        end else begin
            n_quo = $signed({1'b0, r_q[QB]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

[design/grid_cell_pixel_locator.sv]
// throughput: one cell per cycle while the output is not stalled; the 15-step
// restoring divider is fully pipelined
// stalls hold the whole pipeline while a result beat waits at the output
// reset: synchronous active low; clears valid bits and loads register defaults
module grid_cell_pixel_locator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  gcpl_pkg::t_cell_in            i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output gcpl_pkg::t_pix_out            o_data,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [gcpl_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int CO = gcpl_pkg::COEF_W;
    localparam int PW = gcpl_pkg::PROD_W;
    localparam int SW = gcpl_pkg::SUM_W;
    localparam int NW = gcpl_pkg::NUM_W;
    localparam int DW = gcpl_pkg::DEN_W;
    localparam int DL = gcpl_pkg::DIV_LAT;
    localparam int CW = gcpl_pkg::COORD_W;
    localparam int AW = gcpl_pkg::ADDR_W;
    localparam int XW = gcpl_pkg::DIM_W;
    localparam logic signed [SW-1:0] DEN_ONE = SW'(64'sd2147483648);

    // configuration registers
    logic signed [CO-1:0] r_gxu, r_gxv, r_gyu, r_gyv, r_ox, r_oy, r_pu, r_pv;
    logic [XW-1:0] r_width, r_height;
    logic [XW-1:0] w_eff, h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gxu <= CO'(65536);
            r_gxv <= '0;
            r_gyu <= '0;
            r_gyv <= CO'(65536);
            r_ox  <= '0;
            r_oy  <= '0;
            r_pu  <= '0;
            r_pv  <= '0;
            r_width  <= XW'(gcpl_pkg::IMAGE_MAX_DIM);
            r_height <= XW'(gcpl_pkg::IMAGE_MAX_DIM);
        end else if (i_cfg_we) begin
            unique case (gcpl_pkg::t_reg_index'(i_cfg_index))
                gcpl_pkg::REG_X_GAIN_U:     r_gxu <= i_cfg_data[CO-1:0];
                gcpl_pkg::REG_X_GAIN_V:     r_gxv <= i_cfg_data[CO-1:0];
                gcpl_pkg::REG_Y_GAIN_U:     r_gyu <= i_cfg_data[CO-1:0];
                gcpl_pkg::REG_Y_GAIN_V:     r_gyv <= i_cfg_data[CO-1:0];
                gcpl_pkg::REG_ORIGIN_XY: begin
                    r_ox <= i_cfg_data[CO-1:0];
                    r_oy <= i_cfg_data[2*CO-1:CO];
                end
                gcpl_pkg::REG_PERSPECTIVE: begin
                    r_pu <= i_cfg_data[CO-1:0];
                    r_pv <= i_cfg_data[2*CO-1:CO];
                end
                gcpl_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[XW-1:0];
                gcpl_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data[XW-1:0];
                default: ;
            endcase
        end
    end

    // oversized dimensions clamp to the maximum
    assign w_eff = (r_width  > XW'(gcpl_pkg::IMAGE_MAX_DIM)) ?
                   XW'(gcpl_pkg::IMAGE_MAX_DIM) : r_width;
    assign h_eff = (r_height > XW'(gcpl_pkg::IMAGE_MAX_DIM)) ?
                   XW'(gcpl_pkg::IMAGE_MAX_DIM) : r_height;

    // whole pipeline advances unless a result beat is held
    logic en;
    logic r_o_valid;
    assign en      = !r_o_valid || i_ready;
    assign o_ready = en;

    // stage valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic r_vd [0:DL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < DL; i++) r_vd[i] <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_vd[0] <= r_v5;
            for (int i = 1; i < DL; i++) r_vd[i] <= r_vd[i-1];
            r_v6 <= r_vd[DL-1];
            r_o_valid <= r_v6;
        end
    end

    // stage 1: input beat
    logic [7:0] r_col, r_row;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col <= i_data.cell_col;
            r_row <= i_data.cell_row;
        end
    end

    // stage 2: products with the doubled cell centre
    logic signed [gcpl_pkg::UV_W-1:0] u2, v2;
    logic signed [PW-1:0] r_pxu, r_pxv, r_pyu, r_pyv, r_ppu, r_ppv;
    logic r_grid2, r_grid3, r_grid4;
    assign u2 = $signed({1'b0, r_col, 1'b1});
    assign v2 = $signed({1'b0, r_row, 1'b1});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pxu <= r_gxu * u2;
            r_pxv <= r_gxv * v2;
            r_pyu <= r_gyu * u2;
            r_pyv <= r_gyv * v2;
            r_ppu <= r_pu * u2;
            r_ppv <= r_pv * v2;
            r_grid2 <= (r_col < 8'(gcpl_pkg::GRID_MAX_SIZE)) &&
                       (r_row < 8'(gcpl_pkg::GRID_MAX_SIZE));
        end
    end

    // stage 3: numerators and denominator
    logic signed [SW-1:0] r_nx, r_ny, r_den;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx  <= SW'(r_pxu) + SW'(r_pxv) + SW'($signed({r_ox, 1'b0}));
            r_ny  <= SW'(r_pyu) + SW'(r_pyv) + SW'($signed({r_oy, 1'b0}));
            r_den <= SW'(r_ppu) + SW'(r_ppv) + DEN_ONE;
            r_grid3 <= r_grid2;
        end
    end

    // stage 4: dividends with the rounding half, doubled divisor
    logic signed [NW-1:0] r_bx, r_by;
    logic signed [DW-1:0] r_d;
    logic r_dz4;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bx  <= NW'($signed({r_nx, {gcpl_pkg::FRAC_SH{1'b0}}})) + NW'(r_den);
            r_by  <= NW'($signed({r_ny, {gcpl_pkg::FRAC_SH{1'b0}}})) + NW'(r_den);
            r_d   <= $signed({r_den, 1'b0});
            r_dz4 <= (r_den == '0);
            r_grid4 <= r_grid3;
        end
    end

    // stage 5: magnitudes and quotient signs
    logic [NW-1:0] r_mx, r_my;
    logic [DW-1:0] r_md;
    logic r_negx, r_negy;
    gcpl_pkg::t_meta r_meta5;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mx   <= r_bx[NW-1] ? NW'(-r_bx) : NW'(r_bx);
            r_my   <= r_by[NW-1] ? NW'(-r_by) : NW'(r_by);
            r_md   <= r_d[DW-1]  ? DW'(-r_d)  : DW'(r_d);
            r_negx <= r_bx[NW-1] ^ r_d[DW-1];
            r_negy <= r_by[NW-1] ^ r_d[DW-1];
            r_meta5.grid_ok  <= r_grid4;
            r_meta5.den_zero <= r_dz4;
        end
    end

    // dividers, with side information delayed to match
    logic signed [CW-1:0] qx, qy;
    gcpl_pkg::t_meta r_md_line [0:DL-1];

    gcpl_div u_div_x (
        .i_clk (i_clk), .i_en (en), .i_num (r_mx), .i_den (r_md),
        .i_neg (r_negx), .o_quo (qx)
    );
    gcpl_div u_div_y (
        .i_clk (i_clk), .i_en (en), .i_num (r_my), .i_den (r_md),
        .i_neg (r_negy), .o_quo (qy)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_md_line[0] <= r_meta5;
            for (int i = 1; i < DL; i++) r_md_line[i] <= r_md_line[i-1];
        end
    end

    // stage 6: bounds check and row offset
    logic signed [CW-1:0] px, py;
    logic in_bounds;
    logic signed [CW-1:0] r_px6, r_py6;
    logic r_in6;
    logic [24:0] r_row_off;
    assign px = r_md_line[DL-1].den_zero ? '0 : qx;
    assign py = r_md_line[DL-1].den_zero ? '0 : qy;
    assign in_bounds = r_md_line[DL-1].grid_ok && !r_md_line[DL-1].den_zero &&
                       !px[CW-1] && !py[CW-1] &&
                       ({1'b0, px[CW-2:0]} < CW'(w_eff)) &&
                       ({1'b0, py[CW-2:0]} < CW'(h_eff));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px6 <= px;
            r_py6 <= py;
            r_in6 <= in_bounds;
            r_row_off <= py[11:0] * w_eff;
        end
    end

    // stage 7: output register
    gcpl_pkg::t_pix_out r_out;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.pixel_x  <= r_px6;
            r_out.pixel_y  <= r_py6;
            r_out.in_image <= r_in6;
            r_out.pixel_address <= r_in6 ?
                AW'(r_row_off + 25'(r_px6[11:0])) : '0;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_out;

endmodule
